### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, switched off while reset is low.
`define VBFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define VBFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VBFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define VBFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/vbfa_pkg.sv
`timescale 1ns / 1ps

package vbfa_pkg;

    localparam int LEN_W   = 16;   // payload length of one block
    localparam int OFF_W   = 17;   // running heap offset
    localparam int HEAP_W  = 17;   // heap size register
    localparam int REQ_W   = 16;
    localparam int ADDR_W  = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int HEAP_RESET = 1024;
    localparam int HEAP_MIN   = 32;

    localparam int MAX_BLOCKS_DEF     = 64;
    localparam int HEADER_BYTES_DEF   = 16;
    localparam int HEAP_MAX_BYTES_DEF = 65536;

    localparam logic [PADDR_W-1:0] REG_HEAP_BYTES = 3'd0;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_BADFREE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY_A,
        S_APPLY_B,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ROTATE,
        CM_UPDATE,
        CM_CLEAR
    } cell_mode_t;

    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } cell_data_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       wr_en;  // overwrite the addressed cell
        logic       up;     // open a gap at sh_idx
        logic       dn;     // close the entry at sh_idx
    } cell_cmd_t;

endpackage

### hw/rtl/vbfa_cell.sv
`timescale 1ns / 1ps

module vbfa_cell #(
    parameter int MAX_BLOCKS   = vbfa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = vbfa_pkg::HEADER_BYTES_DEF,
    parameter int IDX          = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vbfa_pkg::cell_cmd_t               cmd,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     wr_idx,
    input  logic [$clog2(MAX_BLOCKS)-1:0]     sh_idx,
    input  vbfa_pkg::cell_data_t              wr_data,
    input  logic [vbfa_pkg::LEN_W-1:0]        ins_len,
    input  logic [vbfa_pkg::LEN_W-1:0]        clr_len,
    input  vbfa_pkg::cell_data_t              left,
    input  vbfa_pkg::cell_data_t              right,
    output vbfa_pkg::cell_data_t              q
);
    import vbfa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam logic [IW-1:0] MY = IW'(IDX);
    localparam bit LAST = (IDX == MAX_BLOCKS - 1);
    localparam logic [LEN_W-1:0] RST_LEN =
        (IDX == 0 && HEAP_RESET > HEADER_BYTES) ? LEN_W'(HEAP_RESET - HEADER_BYTES) : '0;

    cell_data_t data_reg;
    cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.mode)
            CM_ROTATE: data_next = right;
            CM_UPDATE:
            begin
                if (cmd.wr_en && MY == wr_idx)
                    data_next = wr_data;
                else if (cmd.up && MY == sh_idx)
                    data_next = '{used: 1'b0, len: ins_len};
                else if (cmd.up && MY > sh_idx)
                    data_next = left;
                else if (cmd.dn && MY >= sh_idx)
                    data_next = LAST ? '0 : right;
            end
            CM_CLEAR:
                data_next = (IDX == 0) ? cell_data_t'{used: 1'b0, len: clr_len} : '0;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '{used: 1'b0, len: RST_LEN};
        else
            data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### hw/rtl/variable_block_fit_allocator_core.sv
`timescale 1ns / 1ps
// Flow: an accepted word is scanned, applied in S_APPLY_A (and S_APPLY_B when a free
// also folds into its predecessor), then moved to the output register from S_RESP once
// that is free. The scan rotates the whole cell ring once; no new word is taken until S_IDLE.
// A new word is taken while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous): heap 1024 bytes, one free block, cursor zero.
`include "assert_macros.svh"

module variable_block_fit_allocator_core #(
    parameter int MAX_BLOCKS     = vbfa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES   = vbfa_pkg::HEADER_BYTES_DEF,
    parameter int HEAP_MAX_BYTES = vbfa_pkg::HEAP_MAX_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [1:0]                    policy,
    input  logic [vbfa_pkg::REQ_W-1:0]    request_bytes,
    input  logic [vbfa_pkg::ADDR_W-1:0]   payload_address,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vbfa_pkg::ADDR_W-1:0]   address,
    output logic [1:0]                    status,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vbfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [vbfa_pkg::PDATA_W-1:0]  pwdata,
    output logic [vbfa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import vbfa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int HEAP_TOP = (HEAP_MAX_BYTES < 65536) ? HEAP_MAX_BYTES : 65536;
    localparam logic [CW-1:0]     MAXC = CW'(MAX_BLOCKS);
    localparam logic [OFF_W-1:0]  HDR  = OFF_W'(HEADER_BYTES);
    localparam logic [HEAP_W-1:0] HTOP = HEAP_W'(HEAP_TOP);
    localparam logic [HEAP_W-1:0] HMIN = HEAP_W'(HEAP_MIN);
    localparam logic [HEAP_W-1:0] HDRH = HEAP_W'(HEADER_BYTES);

    // ------------------------------------------------------------------
    // Cell ring: cell j holds table entry j. During the scan the ring
    // rotates one place a cycle, so cell 0 shows entry n at step n and the
    // table is back in place after MAX_BLOCKS steps. Splits and merges are
    // broadcast shifts that every cell applies together.
    // ------------------------------------------------------------------
    cell_cmd_t           cmd;
    logic [IW-1:0]       wr_idx;
    logic [IW-1:0]       sh_idx;
    cell_data_t          wr_data;
    logic [LEN_W-1:0]    ins_len;
    logic [LEN_W-1:0]    clr_len;
    cell_data_t          cell_q [MAX_BLOCKS];

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        vbfa_cell #(
            .MAX_BLOCKS   (MAX_BLOCKS),
            .HEADER_BYTES (HEADER_BYTES),
            .IDX          (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .wr_idx  (wr_idx),
            .sh_idx  (sh_idx),
            .wr_data (wr_data),
            .ins_len (ins_len),
            .clr_len (clr_len),
            .left    ((g == 0) ? cell_data_t'('0) : cell_q[(g + MAX_BLOCKS - 1) % MAX_BLOCKS]),
            .right   (cell_q[(g + 1) % MAX_BLOCKS]),
            .q       (cell_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [HEAP_W-1:0]   heap_reg, heap_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       cursor_reg, cursor_next;

    logic                op_reg, op_next;
    policy_t             pol_reg, pol_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    logic [CW-1:0]       scan_reg, scan_next;
    logic [OFF_W-1:0]    off_reg, off_next;

    // primary pick (all policies; next fit: at or after the start)
    logic                found_reg, found_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;
    logic [OFF_W-1:0]    poff_reg, poff_next;
    // wrap-round pick for next fit
    logic                fndb_reg, fndb_next;
    logic [IW-1:0]       bidx_reg, bidx_next;
    logic [LEN_W-1:0]    blen_reg, blen_next;
    logic [OFF_W-1:0]    boff_reg, boff_next;

    // free: matched entry and its neighbours
    logic                mfound_reg, mfound_next;
    logic [IW-1:0]       midx_reg, midx_next;
    cell_data_t          mdat_reg, mdat_next;
    cell_data_t          prev_reg, prev_next;
    cell_data_t          nxt_reg, nxt_next;
    logic [LEN_W-1:0]    mrg_reg, mrg_next;

    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             res_stat_reg, res_stat_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    status_t             out_stat_reg, out_stat_next;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic              cfg_wr;
    logic [HEAP_W-1:0] cfg_val;
    logic [HEAP_W-1:0] cfg_sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_HEAP_BYTES);
    assign cfg_val = pwdata[HEAP_W-1:0];
    assign cfg_sat = (cfg_val < HMIN) ? HMIN : ((cfg_val > HTOP) ? HTOP : cfg_val);
    assign prdata = (paddr == REG_HEAP_BYTES) ? PDATA_W'(heap_reg) : '0;
    assign clr_len = (cfg_sat > HDRH) ? LEN_W'(cfg_sat - HDRH) : '0;

    // ------------------------------------------------------------------
    // Scan step view
    // ------------------------------------------------------------------
    cell_data_t        obs;
    logic              n_valid;
    logic              fit;
    logic              scan_last;
    logic [CW-1:0]     start;
    logic              take_a;
    logic              match;

    assign obs       = cell_q[0];
    assign n_valid   = scan_reg < count_reg;
    assign fit       = !obs.used && (obs.len >= req_reg);
    assign scan_last = (scan_reg == MAXC - CW'(1));
    assign start     = (CW'(cursor_reg) < count_reg) ? CW'(cursor_reg) : '0;
    assign match     = (op_reg == OP_FREE) && n_valid && !mfound_reg
                       && ((off_reg + HDR) == OFF_W'(addr_reg));

    always_comb
    begin
        case (pol_reg)
            POL_FIRST: take_a = fit && !found_reg;
            POL_BEST:  take_a = fit && (!found_reg || obs.len < plen_reg);
            POL_WORST: take_a = fit && (!found_reg || obs.len > plen_reg);
            default:   take_a = fit && !found_reg && (scan_reg >= start);
        endcase
    end

    // ------------------------------------------------------------------
    // Apply-phase decisions
    // ------------------------------------------------------------------
    logic              use_b;
    logic              any_pick;
    logic [IW-1:0]     sel_idx;
    logic [LEN_W-1:0]  sel_len;
    logic [OFF_W-1:0]  sel_off;
    logic              split;
    logic [CW-1:0]     ins_pos;
    logic [CW-1:0]     cnt_alloc;
    logic [IW-1:0]     cur_alloc;
    logic              free_ok;
    logic              merge_nxt;
    logic              merge_prv;
    logic [LEN_W-1:0]  len_i;

    assign use_b    = !found_reg && (pol_reg == POL_NEXT) && fndb_reg;
    assign any_pick = found_reg || use_b;
    assign sel_idx  = found_reg ? pidx_reg : bidx_reg;
    assign sel_len  = found_reg ? plen_reg : blen_reg;
    assign sel_off  = found_reg ? poff_reg : boff_reg;
    assign split    = (OFF_W'(sel_len) >= OFF_W'(req_reg) + HDR) && (count_reg < MAXC);
    assign ins_pos  = CW'(sel_idx) + CW'(1);
    assign cnt_alloc = count_reg + CW'(split);

    always_comb
    begin
        cur_alloc = cursor_reg;
        if (split && CW'(cursor_reg) >= ins_pos)
            cur_alloc = cursor_reg + IW'(1);
        if (pol_reg == POL_NEXT)
            cur_alloc = (ins_pos < cnt_alloc) ? ins_pos[IW-1:0] : '0;
    end

    assign free_ok   = mfound_reg && mdat_reg.used;
    assign merge_nxt = (CW'(midx_reg) + CW'(1) < count_reg) && !nxt_reg.used;
    assign merge_prv = (midx_reg != '0) && !prev_reg.used;
    assign len_i     = merge_nxt ? LEN_W'(OFF_W'(mdat_reg.len) + HDR + OFF_W'(nxt_reg.len))
                                 : mdat_reg.len;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_SCAN;
            S_SCAN:    if (scan_last) state_next = S_APPLY_A;
            S_APPLY_A:
                state_next = (op_reg == OP_FREE && free_ok && merge_prv) ? S_APPLY_B : S_RESP;
            S_APPLY_B: state_next = S_RESP;
            S_RESP:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs: cell commands and datapath updates
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '{mode: CM_HOLD, wr_en: 1'b0, up: 1'b0, dn: 1'b0};
        wr_idx     = '0;
        sh_idx     = '0;
        wr_data    = '0;
        ins_len    = '0;

        heap_next   = heap_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        op_next     = op_reg;
        pol_next    = pol_reg;
        req_next    = req_reg;
        addr_next   = addr_reg;
        scan_next   = scan_reg;
        off_next    = off_reg;
        found_next  = found_reg;
        pidx_next   = pidx_reg;
        plen_next   = plen_reg;
        poff_next   = poff_reg;
        fndb_next   = fndb_reg;
        bidx_next   = bidx_reg;
        blen_next   = blen_reg;
        boff_next   = boff_reg;
        mfound_next = mfound_reg;
        midx_next   = midx_reg;
        mdat_next   = mdat_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        mrg_next    = mrg_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr)
                begin
                    // table back to one free block
                    cmd.mode    = CM_CLEAR;
                    heap_next   = cfg_sat;
                    count_next  = CW'(1);
                    cursor_next = '0;
                end
                if (in_valid)
                begin
                    op_next     = operation;
                    pol_next    = policy_t'(policy);
                    req_next    = (request_bytes == '0) ? REQ_W'(1) : request_bytes;
                    addr_next   = payload_address;
                    scan_next   = '0;
                    off_next    = '0;
                    found_next  = 1'b0;
                    fndb_next   = 1'b0;
                    mfound_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                cmd.mode  = CM_ROTATE;
                scan_next = scan_reg + CW'(1);
                if (n_valid)
                begin
                    off_next = off_reg + HDR + OFF_W'(obs.len);
                    if (op_reg == OP_ALLOC)
                    begin
                        if (take_a)
                        begin
                            found_next = 1'b1;
                            pidx_next  = scan_reg[IW-1:0];
                            plen_next  = obs.len;
                            poff_next  = off_reg;
                        end
                        if (pol_reg == POL_NEXT && fit && !fndb_reg)
                        begin
                            fndb_next = 1'b1;
                            bidx_next = scan_reg[IW-1:0];
                            blen_next = obs.len;
                            boff_next = off_reg;
                        end
                    end
                    else
                    begin
                        if (match)
                        begin
                            mfound_next = 1'b1;
                            midx_next   = scan_reg[IW-1:0];
                            mdat_next   = obs;
                        end
                        else if (!mfound_reg)
                            prev_next = obs;
                        if (mfound_reg && scan_reg == CW'(midx_reg) + CW'(1))
                            nxt_next = obs;
                    end
                end
            end
            S_APPLY_A:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (any_pick)
                    begin
                        cmd      = '{mode: CM_UPDATE, wr_en: 1'b1, up: split, dn: 1'b0};
                        wr_idx   = sel_idx;
                        wr_data  = '{used: 1'b1, len: split ? req_reg : sel_len};
                        sh_idx   = ins_pos[IW-1:0];
                        ins_len  = LEN_W'(OFF_W'(sel_len) - OFF_W'(req_reg) - HDR);
                        count_next    = cnt_alloc;
                        cursor_next   = cur_alloc;
                        res_addr_next = ADDR_W'(sel_off + HDR);
                        res_stat_next = STAT_OK;
                    end
                    else
                    begin
                        res_addr_next = '0;
                        res_stat_next = STAT_NOFIT;
                    end
                end
                else
                begin
                    res_addr_next = '0;
                    if (free_ok)
                    begin
                        // mark free, absorb a free successor
                        cmd     = '{mode: CM_UPDATE, wr_en: 1'b1, up: 1'b0, dn: merge_nxt};
                        wr_idx  = midx_reg;
                        wr_data = '{used: 1'b0, len: len_i};
                        sh_idx  = midx_reg + IW'(1);
                        mrg_next = len_i;
                        if (merge_nxt)
                        begin
                            count_next = count_reg - CW'(1);
                            if (CW'(cursor_reg) >= CW'(midx_reg) + CW'(1))
                                cursor_next = cursor_reg - IW'(1);
                        end
                        res_stat_next = STAT_OK;
                    end
                    else
                        res_stat_next = STAT_BADFREE;
                end
            end
            S_APPLY_B:
            begin
                // fold into the free predecessor
                cmd     = '{mode: CM_UPDATE, wr_en: 1'b1, up: 1'b0, dn: 1'b1};
                wr_idx  = midx_reg - IW'(1);
                wr_data = '{used: 1'b0,
                            len: LEN_W'(OFF_W'(prev_reg.len) + HDR + OFF_W'(mrg_reg))};
                sh_idx  = midx_reg;
                count_next = count_reg - CW'(1);
                if (cursor_reg >= midx_reg)
                    cursor_next = cursor_reg - IW'(1);
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_stat_next  = res_stat_reg;
                end
            end
            default: cmd.mode = CM_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_reg      <= HEAP_W'(HEAP_RESET);
            count_reg     <= CW'(1);
            cursor_reg    <= '0;
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            fndb_reg      <= 1'b0;
            mfound_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_reg      <= heap_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            fndb_reg      <= fndb_next;
            mfound_reg    <= mfound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pol_reg      <= pol_next;
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        off_reg      <= off_next;
        pidx_reg     <= pidx_next;
        plen_reg     <= plen_next;
        poff_reg     <= poff_next;
        bidx_reg     <= bidx_next;
        blen_reg     <= blen_next;
        boff_reg     <= boff_next;
        midx_reg     <= midx_next;
        mdat_reg     <= mdat_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        mrg_reg      <= mrg_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
    end

    assign out_valid = out_valid_reg;
    assign address   = out_addr_reg;
    assign status    = out_stat_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `VBFA_ASSERT_ALWAYS(a_count_range, clk, !rst_n || ((count_reg >= CW'(1)) && (count_reg <= MAXC)), "block count out of range")
    `VBFA_ASSERT(a_accept_scan, clk, rst_n, (in_valid && in_ready) |=> (state_reg == S_SCAN) && (scan_reg == '0), "accepted word did not start a scan")
    `VBFA_ASSERT(a_scan_end, clk, rst_n, (state_reg == S_SCAN && scan_last) |=> (state_reg == S_APPLY_A), "scan did not end after one full ring turn")
    `VBFA_ASSERT(a_merge_b, clk, rst_n, (state_reg == S_APPLY_B) |-> (op_reg == OP_FREE) && (midx_reg != '0), "predecessor merge without a valid free")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Allocator testbench: a behavioural heap table predicts each result word,
// scoreboard checks the result stream in order.

class heap_scoreboard;
    localparam int NBLK = vbfa_pkg::MAX_BLOCKS_DEF;
    localparam int HDR  = vbfa_pkg::HEADER_BYTES_DEF;

    int unsigned heap_size;
    int unsigned blk_len[NBLK];
    bit          blk_used[NBLK];
    int unsigned blk_count;
    int unsigned cursor;
    logic [15:0] want_addr[$];
    logic [1:0]  want_stat[$];
    int          errors;

    function void clear_table();
        for (int k = 0; k < NBLK; k++)
        begin
            blk_len[k]  = 0;
            blk_used[k] = 0;
        end
        blk_len[0] = heap_size > HDR ? heap_size - HDR : 0;
        blk_count  = 1;
        cursor     = 0;
    endfunction

    function void set_heap(int unsigned v);
        v = v & 17'h1FFFF;
        if (v < vbfa_pkg::HEAP_MIN) v = vbfa_pkg::HEAP_MIN;
        if (v > 65536) v = 65536;
        heap_size = v;
        clear_table();
    endfunction

    function int unsigned offset_of(int unsigned idx);
        int unsigned off;
        off = 0;
        for (int j = 0; j < idx; j++) off += HDR + blk_len[j];
        return off + HDR;
    endfunction

    function void drop(int unsigned k);
        if (k == 0 || k >= blk_count) return;
        for (int j = k; j < blk_count - 1; j++)
        begin
            blk_len[j]  = blk_len[j+1];
            blk_used[j] = blk_used[j+1];
        end
        blk_count--;
        blk_len[blk_count]  = 0;
        blk_used[blk_count] = 0;
        if (cursor >= k) cursor--;
    endfunction

    function void split_after(int unsigned k, int unsigned len);
        int unsigned p;
        p = k + 1;
        if (blk_count >= NBLK || p > blk_count) return;
        for (int j = blk_count; j > p; j--)
        begin
            blk_len[j]  = blk_len[j-1];
            blk_used[j] = blk_used[j-1];
        end
        blk_len[p]  = len;
        blk_used[p] = 0;
        blk_count++;
        if (cursor >= p) cursor++;
    endfunction

    function void do_alloc(vbfa_pkg::policy_t pol, int unsigned req,
                           output logic [15:0] a, output logic [1:0] s);
        int unsigned pick, start, i;
        bit found;
        found = 0;
        pick  = 0;
        if (req == 0) req = 1;
        if (pol == vbfa_pkg::POL_NEXT)
        begin
            start = cursor < blk_count ? cursor : 0;
            for (int n = 0; n < blk_count && !found; n++)
            begin
                i = (start + n) % blk_count;
                if (!blk_used[i] && blk_len[i] >= req)
                begin
                    pick  = i;
                    found = 1;
                end
            end
        end
        else
        begin
            for (int k = 0; k < blk_count; k++)
            begin
                if (blk_used[k] || blk_len[k] < req) continue;
                if (!found || (pol == vbfa_pkg::POL_BEST && blk_len[k] < blk_len[pick]) ||
                    (pol == vbfa_pkg::POL_WORST && blk_len[k] > blk_len[pick]))
                begin
                    pick  = k;
                    found = 1;
                    if (pol == vbfa_pkg::POL_FIRST) break;
                end
            end
        end
        if (!found)
        begin
            a = 0;
            s = vbfa_pkg::STAT_NOFIT;
            return;
        end
        if (blk_len[pick] >= req + HDR && blk_count < NBLK)
        begin
            start = blk_len[pick] - req - HDR;
            blk_len[pick] = req;
            split_after(pick, start);
        end
        blk_used[pick] = 1;
        if (pol == vbfa_pkg::POL_NEXT) cursor = (pick + 1 < blk_count) ? pick + 1 : 0;
        a = 16'(offset_of(pick));
        s = vbfa_pkg::STAT_OK;
    endfunction

    function void do_free(int unsigned addr, output logic [1:0] s);
        int unsigned i, off;
        off = 0;
        for (i = 0; i < blk_count; i++)
        begin
            if (off + HDR == addr) break;
            off += HDR + blk_len[i];
        end
        if (i >= blk_count || !blk_used[i])
        begin
            s = vbfa_pkg::STAT_BADFREE;
            return;
        end
        blk_used[i] = 0;
        if (i + 1 < blk_count && !blk_used[i+1])
        begin
            blk_len[i] += HDR + blk_len[i+1];
            drop(i + 1);
        end
        if (i > 0 && !blk_used[i-1])
        begin
            blk_len[i-1] += HDR + blk_len[i];
            drop(i);
        end
        s = vbfa_pkg::STAT_OK;
    endfunction

    // note an accepted word and queue what it should produce
    function void note_request(logic op, logic [1:0] pol, logic [15:0] req, logic [15:0] pa);
        logic [15:0] a;
        logic [1:0]  s;
        a = 0;
        if (op == vbfa_pkg::OP_ALLOC) do_alloc(vbfa_pkg::policy_t'(pol), 32'(req), a, s);
        else do_free(32'(pa), s);
        want_addr.push_back(a);
        want_stat.push_back(s);
    endfunction

    function void check_result(logic [15:0] a, logic [1:0] s);
        logic [15:0] ea;
        logic [1:0]  es;
        if (want_addr.size() == 0)
        begin
            $error("unexpected result word address=%0d status=%0d", a, s);
            errors++;
            return;
        end
        ea = want_addr.pop_front();
        es = want_stat.pop_front();
        if (a !== ea)
        begin
            $error("address: expected %0d actual %0d", ea, a);
            errors++;
        end
        if (s !== es)
        begin
            $error("status: expected %0d actual %0d", es, s);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import vbfa_pkg::*;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0, in_ready;
    logic              operation = 0;
    logic [1:0]        policy = 0;
    logic [15:0]       request_bytes = 0, payload_address = 0;
    logic              out_valid, out_ready = 0;
    logic [15:0]       address;
    logic [1:0]        status;
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = 0;
    logic [PDATA_W-1:0] pwdata = 0, prdata;
    logic              pready;

    heap_scoreboard sb;
    int  cycles;
    bit  hold_off;        // long receiver stall requested
    logic [15:0] live[$]; // payloads believed to be allocated

    always #4 clk = ~clk;

    variable_block_fit_allocator_core dut (.*);

    // cycle limit: ~1100 words plus gaps and stalls, taken several times
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall per word, plus one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 0;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_result(address, status);
        end
    end

    task automatic apb_write(logic [PADDR_W-1:0] a, logic [31:0] d);
        psel <= 1; pwrite <= 1; paddr <= a; pwdata <= d; penable <= 0;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_heap(d);
    endtask

    // valid is dropped only when a gap follows, so back-to-back words see one update
    task automatic send_word(logic op, logic [1:0] pol, logic [15:0] req, logic [15:0] pa,
                             bit nogap);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1; operation <= op; policy <= pol;
        request_bytes <= req; payload_address <= pa;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(op, pol, req, pa);
        if (op == OP_ALLOC && sb.want_stat[$] == STAT_OK) live.push_back(sb.want_addr[$]);
    endtask

    task automatic alloc(logic [1:0] pol, logic [15:0] req);
        send_word(OP_ALLOC, pol, req, 16'($urandom), 0);
    endtask

    task automatic free_addr(logic [15:0] pa);
        send_word(OP_FREE, 2'($urandom), 16'($urandom), pa, 0);
    endtask

    task automatic free_live();
        int k;
        logic [15:0] pa;
        if (live.size() == 0)
        begin
            free_addr(16'($urandom));
            return;
        end
        k  = $urandom_range(0, live.size() - 1);
        pa = live[k];
        live.delete(k);
        free_addr(pa);
    endtask

    // drain before a register write so the block is back in idle, then pad
    task automatic settle();
        in_valid <= 0;
        while (sb.want_addr.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_phase(int n, int maxreq);
        for (int k = 0; k < n; k++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 55) alloc(2'($urandom), 16'($urandom_range(0, maxreq)));
            else if (r < 90) free_live();
            else if (r < 95) free_addr(16'($urandom));
            else alloc(2'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.heap_size = HEAP_RESET;
        sb.clear_table();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every policy, exact fit, zero request, bad frees
        alloc(POL_FIRST, 0);
        alloc(POL_FIRST, 16'hFFFF);
        alloc(POL_BEST, 100);
        alloc(POL_WORST, 50);
        alloc(POL_NEXT, 8);
        free_addr(16'd17);
        free_addr(16'hFFFF);
        free_addr(16'd0);
        free_addr(16'd48);
        free_live();
        alloc(POL_BEST, 100);
        free_live();
        free_live();
        alloc(POL_NEXT, 200);
        alloc(POL_WORST, 1);
        free_live();
        free_live();
        free_live();
        free_addr(16'd16);
        settle();
        live.delete();
        apb_write(REG_HEAP_BYTES, 0);        // saturates to the minimum
        alloc(POL_FIRST, 16);                // exact fit, no room for a header
        alloc(POL_FIRST, 1);
        free_addr(16'd16);
        settle();
        live.delete();
        apb_write(REG_HEAP_BYTES, 32'h1FFFF); // saturates to 64 KiB

        // fill the table, the receiver stalls long while words keep coming
        hold_off = 1;
        for (int k = 0; k < 70; k++)
            send_word(OP_ALLOC, POL_FIRST, 16'($urandom_range(1, 40)), 16'd0, 1);
        random_phase(250, 3000);
        settle();
        live.delete();
        apb_write(REG_HEAP_BYTES, 32'd65535);
        random_phase(250, 600);
        settle();
        live.delete();
        apb_write(REG_HEAP_BYTES, 32'd300);
        random_phase(200, 64);
        settle();
        live.delete();
        apb_write(REG_HEAP_BYTES, $urandom_range(32, 65536));
        random_phase(250, 2000);

        in_valid <= 0;
        while (sb.want_addr.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
